// ----- src/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority task queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int ENTRIES = 16;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int OP_W    = 2;
  localparam int ID_W    = 8;
  localparam int PRIO_W  = 16;
  localparam int ST_W    = 2;
  localparam int OCC_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_TOP = 2'd1,
    OP_REMOVE_ID  = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic                     valid;
    logic signed [PRIO_W-1:0] prio;
    logic [ID_W-1:0]          task_id;
  } entry_t;

  typedef struct packed {
    logic                     ins;
    logic                     rem_id;
    logic [ID_W-1:0]          task_id;
    logic signed [PRIO_W-1:0] prio;
  } cmd_t;

endpackage

// ----- src/sorted_priority_task_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_task_queue
// Sorted priority queue of task entries built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries an operation (insert, remove top,
// remove by task id), a task id and a signed priority. Every transaction
// yields exactly one result transaction with status, removed id, the top
// id after the operation, a top valid flag and the occupancy.
// All cells compare against the broadcast command in the same cycle and
// shift toward or away from the top, so one operation completes per cycle
// while results are taken. out_valid rises in the cycle after acceptance;
// throughput is one transaction per cycle, set by the single result register.
// The queue accepts a new transaction while a result is pending as long as
// that result is taken in the same cycle; when the receiver stalls, the
// result register holds and in_ready drops until it is taken.
// Reset empties the queue (all slot valid bits and the count are cleared)
// and drops any pending result.
// ----------------------------------------------------------------------------
module sorted_priority_task_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [spq_pkg::OP_W-1:0]         in_op,
  input  logic [spq_pkg::ID_W-1:0]         in_task_id,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [spq_pkg::ST_W-1:0]         out_status,
  output logic [spq_pkg::ID_W-1:0]         out_removed_id,
  output logic                             out_top_valid,
  output logic [spq_pkg::ID_W-1:0]         out_top_id,
  output logic [spq_pkg::OCC_W-1:0]        out_occupancy
);

  localparam int N = spq_pkg::ENTRIES;

  spq_pkg::entry_t              cur   [N];
  spq_pkg::entry_t              nxt   [N];
  spq_pkg::entry_t              upper [N];
  spq_pkg::entry_t              lower [N];
  logic [N:0]                   go;
  logic [N:0]                   seen;
  spq_pkg::cmd_t                cmd;
  spq_pkg::entry_t              empty_entry;

  logic                         accept;
  logic                         full;
  logic                         empty;
  logic                         found;
  logic                         do_ins;
  logic                         do_rem;
  logic                         rem_top;
  spq_pkg::status_t             status;
  logic [spq_pkg::ID_W-1:0]     removed;

  logic [spq_pkg::CNT_W-1:0]    count_r;
  logic [spq_pkg::CNT_W-1:0]    count_nxt;
  logic                         out_valid_r;
  logic [spq_pkg::ST_W-1:0]     status_r;
  logic [spq_pkg::ID_W-1:0]     removed_r;
  logic                         top_valid_r;
  logic [spq_pkg::ID_W-1:0]     top_id_r;
  logic [spq_pkg::OCC_W-1:0]    occ_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign empty_entry.valid   = 1'b0;
  assign empty_entry.prio    = '0;
  assign empty_entry.task_id = '0;

  assign full  = cur[N-1].valid;
  assign empty = !cur[0].valid;
  assign found = seen[N];

  always_comb begin
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    rem_top = 1'b0;
    unique case (spq_pkg::op_t'(in_op))
      spq_pkg::OP_INSERT:     do_ins = accept && !full;
      spq_pkg::OP_REMOVE_TOP: rem_top = accept && !empty;
      spq_pkg::OP_REMOVE_ID:  do_rem = accept && !empty;
      default: ;
    endcase
  end

  assign cmd.ins     = do_ins;
  assign cmd.rem_id  = do_rem;
  assign cmd.task_id = in_task_id;
  assign cmd.prio    = in_priority_req;

  assign go[0]   = 1'b0;
  assign seen[0] = rem_top;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign upper[i] = empty_entry;
    end else begin : g_mid_u
      assign upper[i] = cur[i-1];
    end
    if (i == N - 1) begin : g_last
      assign lower[i] = empty_entry;
    end else begin : g_mid_l
      assign lower[i] = cur[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .upper_entry (upper[i]),
      .lower_entry (lower[i]),
      .go_in       (go[i]),
      .go_out      (go[i+1]),
      .seen_in     (seen[i]),
      .seen_out    (seen[i+1]),
      .entry       (cur[i]),
      .entry_nxt   (nxt[i])
    );
  end

  always_comb begin
    status    = spq_pkg::ST_OK;
    removed   = '0;
    count_nxt = count_r;
    unique case (spq_pkg::op_t'(in_op))
      spq_pkg::OP_INSERT: begin
        if (full) begin
          status = spq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      spq_pkg::OP_REMOVE_TOP: begin
        if (empty) begin
          status = spq_pkg::ST_EMPTY;
        end else begin
          removed   = cur[0].task_id;
          count_nxt = count_r - 1'b1;
        end
      end
      spq_pkg::OP_REMOVE_ID: begin
        if (empty) begin
          status = spq_pkg::ST_EMPTY;
        end else if (!found) begin
          status = spq_pkg::ST_NOTFOUND;
        end else begin
          removed   = in_task_id;
          count_nxt = count_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      status_r    <= status;
      removed_r   <= removed;
      top_valid_r <= nxt[0].valid;
      top_id_r    <= nxt[0].valid ? nxt[0].task_id : '0;
      occ_r       <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_removed_id = removed_r;
  assign out_top_valid  = top_valid_r;
  assign out_top_id     = top_id_r;
  assign out_occupancy  = occ_r;

endmodule

// ----- src/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds an entry and shifts toward or away
// from the top together with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  spq_pkg::cmd_t    cmd,
  input  spq_pkg::entry_t  upper_entry,
  input  spq_pkg::entry_t  lower_entry,
  input  logic             go_in,
  output logic             go_out,
  input  logic             seen_in,
  output logic             seen_out,
  output spq_pkg::entry_t  entry,
  output spq_pkg::entry_t  entry_nxt
);

  logic                             valid_r;
  logic signed [spq_pkg::PRIO_W-1:0] prio_r;
  logic [spq_pkg::ID_W-1:0]         task_r;
  spq_pkg::entry_t                  new_entry;
  logic                             match;

  assign entry.valid   = valid_r;
  assign entry.prio    = prio_r;
  assign entry.task_id = task_r;

  // insert position is the first slot that is empty or holds a lower priority
  assign go_out = !(valid_r && (prio_r >= cmd.prio));
  assign match  = cmd.rem_id && valid_r && (task_r == cmd.task_id);
  assign seen_out = seen_in || match;

  always_comb begin
    new_entry.valid   = 1'b1;
    new_entry.prio    = cmd.prio;
    new_entry.task_id = cmd.task_id;
    entry_nxt = entry;
    if (cmd.ins) begin
      if (go_in) begin
        entry_nxt = upper_entry;
      end else if (go_out) begin
        entry_nxt = new_entry;
      end
    end else if (seen_out) begin
      entry_nxt = lower_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= entry_nxt.valid;
    end
    prio_r <= entry_nxt.prio;
    task_r <= entry_nxt.task_id;
  end

endmodule
